// File: rtl/dcalc_pkg.sv
// Shared constants, codes and types of the decimal expression calculator.
package dcalc_pkg;

  // Word buffer size; a word may hold at most WORD_BUFFER-1 characters
  localparam int WORD_BUFFER = 16;
  localparam int LEN_W       = $clog2(WORD_BUFFER);
  localparam int ACC_W       = 31;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(DATA_W);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WORD_BUFFER - 1);
  localparam logic [ACC_W-1:0] NUMBER_LIMIT = ACC_W'(200000000);

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_TIMES = 8'h78;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_REM  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  // Operands and operator of one finished line
  typedef struct packed {
    op_e              op;
    logic             bad;
    logic [ACC_W-1:0] x_mag;
    logic             x_neg;
    logic [ACC_W-1:0] y_mag;
    logic             y_neg;
  } job_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    status_e           status;
  } result_t;

endpackage

// File: rtl/decimal_expression_calculator.sv
// Top level of the decimal expression calculator: parser, serial ALU, output register.
//
// Input channel: one character word per accepted transfer (char_code_i, end_of_line_i),
// valid/ready. A character code of zero is skipped; end_of_line_i closes the line.
// Output channel: one result word per line (value_o, status_o), valid/ready.
// Characters are taken one per cycle while the arithmetic unit is idle.
// After the end-of-line word the input stalls while the ALU works:
//   bad line or divide by zero: result decided in the prepare step,
//   add or subtract: an add step after the prepare step,
//   multiply, divide, remainder: 32 shift-add or restoring steps
//   of the bit-serial unit, one bit per cycle.
// The next line's characters are taken while a result waits in the output
// register. If the receiver stalls, a second finished result waits in the ALU
// and input stays stalled until the output register frees.
// Reset clears the parser, the ALU sequencer and the output valid; the block
// is ready for characters as soon as reset is released.
module decimal_expression_calculator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         char_code_i,
  input  logic               end_of_line_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_o,
  output logic [1:0]         status_o
);
  import dcalc_pkg::*;

  logic    accept;
  logic    alu_idle, alu_done, take;
  job_t    job;
  result_t alu_res;

  logic              out_valid_q;
  logic [DATA_W-1:0] value_q;
  status_e           status_q;

  assign in_ready_o = alu_idle;
  assign accept     = in_valid_i && in_ready_o;
  assign take       = alu_done && (!out_valid_q || out_ready_i);

  dcalc_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .char_code_i   (char_code_i),
    .end_of_line_i (end_of_line_i),
    .job_o         (job)
  );

  dcalc_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && end_of_line_i),
    .job_i   (job),
    .take_i  (take),
    .idle_o  (alu_idle),
    .done_o  (alu_done),
    .res_o   (alu_res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      value_q     <= '0;
      status_q    <= ST_OK;
    end else if (take) begin
      out_valid_q <= 1'b1;
      value_q     <= alu_res.value;
      status_q    <= alu_res.status;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  // Checks
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (value_o == '0))
    else $error("nonzero value with error status");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_BAD || status_o == ST_DIV0))
    else $error("undefined status code");

  a_eol_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_line_i) |=> !in_ready_o)
    else $error("input ready right after end of line");

  a_take_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_o)
    else $error("finished result not loaded into output register");

endmodule

// File: rtl/dcalc_parser.sv
// Character parser: splits the line into words and collects operands and operator.
module dcalc_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        char_code_i,
  input  logic              end_of_line_i,
  output dcalc_pkg::job_t   job_o
);
  import dcalc_pkg::*;

  logic [ACC_W-1:0] acc_q, acc_d;
  logic             neg_q, neg_d;
  logic             dig_q, dig_d;
  logic             wbad_q, wbad_d;
  logic [1:0]       widx_q, widx_d;
  logic [LEN_W-1:0] wlen_q, wlen_d;
  logic             inw_q, inw_d;
  op_e              opc_q, opc_d;
  logic [ACC_W-1:0] xmag_q, xmag_d;
  logic             xneg_q, xneg_d;
  logic             lbad_q, lbad_d;

  logic             is_ws;
  logic             is_digit;
  logic             at_first;
  op_e              char_op;
  logic [ACC_W-1:0] acc_x10;

  assign is_ws    = (char_code_i == CH_SPACE) || (char_code_i == CH_TAB);
  assign is_digit = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);

  // Operator character decode
  always_comb begin
    unique case (char_code_i)
      CH_PLUS:  char_op = OP_ADD;
      CH_MINUS: char_op = OP_SUB;
      CH_TIMES: char_op = OP_MUL;
      CH_SLASH: char_op = OP_DIV;
      CH_PCT:   char_op = OP_REM;
      default:  char_op = OP_NONE;
    endcase
  end

  // Feed one character, then close the word on a blank or at end of line
  always_comb begin
    acc_d  = acc_q;
    neg_d  = neg_q;
    dig_d  = dig_q;
    wbad_d = wbad_q;
    widx_d = widx_q;
    wlen_d = wlen_q;
    inw_d  = inw_q;
    opc_d  = opc_q;
    xmag_d = xmag_q;
    xneg_d = xneg_q;
    lbad_d = lbad_q;
    at_first = 1'b0;
    acc_x10  = '0;

    if (char_code_i != CH_NUL && !is_ws) begin
      if (!inw_d) begin
        inw_d  = 1'b1;
        wlen_d = '0;
        wbad_d = 1'b0;
        dig_d  = 1'b0;
        if (widx_d == 2'd0 || widx_d == 2'd2) begin
          acc_d = '0;
          neg_d = 1'b0;
        end else if (widx_d == 2'd1) begin
          opc_d = OP_NONE;
        end
      end
      if (widx_d != 2'd3) begin
        if (wlen_d >= LEN_MAX) begin
          wbad_d = 1'b1;
        end else begin
          at_first = (wlen_d == '0);
          wlen_d   = wlen_d + LEN_W'(1);
          if (widx_d == 2'd1) begin
            if (at_first) opc_d = char_op;
            else wbad_d = 1'b1;
          end else if (is_digit) begin
            if (acc_d > NUMBER_LIMIT) begin
              wbad_d = 1'b1;
            end else begin
              acc_x10 = {acc_d[ACC_W-4:0], 3'b000} + {acc_d[ACC_W-2:0], 1'b0};
              acc_d   = acc_x10 + ACC_W'(char_code_i[3:0]);
              dig_d   = 1'b1;
            end
          end else if (at_first && char_code_i == CH_MINUS) begin
            neg_d = 1'b1;
          end else if (!(at_first && char_code_i == CH_PLUS)) begin
            wbad_d = 1'b1;
          end
        end
      end
    end

    if (((char_code_i != CH_NUL) && is_ws) || end_of_line_i) begin
      if (inw_d) begin
        if (widx_d == 2'd0 || widx_d == 2'd2) begin
          if (wbad_d || !dig_d) begin
            lbad_d = 1'b1;
          end else if (widx_d == 2'd0) begin
            xmag_d = acc_d;
            xneg_d = neg_d;
          end
        end else if (widx_d == 2'd1) begin
          if (wbad_d) opc_d = OP_NONE;
          if (opc_d == OP_NONE) lbad_d = 1'b1;
        end
        if (widx_d != 2'd3) widx_d = widx_d + 2'd1;
        inw_d = 1'b0;
      end
    end
  end

  // Job handed to the arithmetic unit at end of line
  always_comb begin
    job_o.op    = opc_d;
    job_o.bad   = lbad_d || (widx_d != 2'd3) || (opc_d == OP_NONE);
    job_o.x_mag = xmag_d;
    job_o.x_neg = xneg_d;
    job_o.y_mag = acc_d;
    job_o.y_neg = neg_d;
  end

  // Word state; cleared after each line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      neg_q  <= 1'b0;
      dig_q  <= 1'b0;
      wbad_q <= 1'b0;
      widx_q <= '0;
      wlen_q <= '0;
      inw_q  <= 1'b0;
      opc_q  <= OP_NONE;
      xmag_q <= '0;
      xneg_q <= 1'b0;
      lbad_q <= 1'b0;
    end else if (step_i) begin
      if (end_of_line_i) begin
        acc_q  <= '0;
        neg_q  <= 1'b0;
        dig_q  <= 1'b0;
        wbad_q <= 1'b0;
        widx_q <= '0;
        wlen_q <= '0;
        inw_q  <= 1'b0;
        opc_q  <= OP_NONE;
        xmag_q <= '0;
        xneg_q <= 1'b0;
        lbad_q <= 1'b0;
      end else begin
        acc_q  <= acc_d;
        neg_q  <= neg_d;
        dig_q  <= dig_d;
        wbad_q <= wbad_d;
        widx_q <= widx_d;
        wlen_q <= wlen_d;
        inw_q  <= inw_d;
        opc_q  <= opc_d;
        xmag_q <= xmag_d;
        xneg_q <= xneg_d;
        lbad_q <= lbad_d;
      end
    end
  end

endmodule

// File: rtl/dcalc_alu.sv
// Bit-serial arithmetic unit: add/sub in one step, multiply and divide one bit per cycle.
module dcalc_alu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  dcalc_pkg::job_t     job_i,
  input  logic                take_i,
  output logic                idle_o,
  output logic                done_o,
  output dcalc_pkg::result_t  res_o
);
  import dcalc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_ADD,
    S_RUN,
    S_FIN,
    S_DONE
  } alu_state_e;

  alu_state_e        state_q;
  op_e               op_q;
  logic              bad_q;
  logic              xn_q, yn_q, rneg_q;
  logic [DATA_W-1:0] a_q, b_q, acc_q;
  logic [CNT_W-1:0]  cnt_q;
  result_t           res_q;

  logic [DATA_W:0]   shifted, diff;
  logic              ge;
  logic [DATA_W-1:0] fin_mag;

  // One restoring division step
  always_comb begin
    shifted = {acc_q, a_q[DATA_W-1]};
    diff    = shifted - {1'b0, b_q};
    ge      = !diff[DATA_W];
    fin_mag = (op_q == OP_DIV) ? a_q : acc_q;
  end

  assign idle_o = (state_q == S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign res_o  = res_q;

  // Sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_NONE;
      bad_q   <= 1'b0;
      xn_q    <= 1'b0;
      yn_q    <= 1'b0;
      rneg_q  <= 1'b0;
      a_q     <= '0;
      b_q     <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            op_q    <= job_i.op;
            bad_q   <= job_i.bad;
            xn_q    <= job_i.x_neg;
            yn_q    <= job_i.y_neg;
            a_q     <= DATA_W'(job_i.x_mag);
            b_q     <= DATA_W'(job_i.y_mag);
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          cnt_q  <= '0;
          acc_q  <= '0;
          rneg_q <= (op_q == OP_REM) ? xn_q : (xn_q ^ yn_q);
          if (bad_q) begin
            res_q.value  <= '0;
            res_q.status <= ST_BAD;
            state_q      <= S_DONE;
          end else if ((op_q == OP_DIV || op_q == OP_REM) && b_q == '0) begin
            res_q.value  <= '0;
            res_q.status <= ST_DIV0;
            state_q      <= S_DONE;
          end else if (op_q == OP_ADD || op_q == OP_SUB) begin
            a_q     <= xn_q ? (DATA_W'(0) - a_q) : a_q;
            b_q     <= yn_q ? (DATA_W'(0) - b_q) : b_q;
            state_q <= S_ADD;
          end else begin
            state_q <= S_RUN;
          end
        end
        S_ADD: begin
          acc_q   <= (op_q == OP_SUB) ? (a_q - b_q) : (a_q + b_q);
          rneg_q  <= 1'b0;
          state_q <= S_FIN;
        end
        S_RUN: begin
          if (op_q == OP_MUL) begin
            acc_q <= acc_q + (b_q[0] ? a_q : '0);
            a_q   <= {a_q[DATA_W-2:0], 1'b0};
            b_q   <= {1'b0, b_q[DATA_W-1:1]};
          end else begin
            acc_q <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            a_q   <= {a_q[DATA_W-2:0], ge};
          end
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == '1) state_q <= S_FIN;
        end
        S_FIN: begin
          res_q.value  <= rneg_q ? (DATA_W'(0) - fin_mag) : fin_mag;
          res_q.status <= ST_OK;
          state_q      <= S_DONE;
        end
        S_DONE: begin
          if (take_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
